### hw/rtl/sfs_pkg.sv
// Shared types, codes and widths for the sprite frame sequencer.
`default_nettype none
package sfs_pkg;

  localparam int PAT_W  = 8;
  localparam int TICK_W = 17;
  localparam int IVL_W  = 16;
  localparam int COL_W  = 8;
  localparam int TILE_W = 17;
  localparam int OFF_W  = 24;
  localparam int CMD_W  = 2;
  localparam int MODE_W = 3;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 17;
  localparam int PROD_W = PAT_W + TILE_W;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic [OFF_W-1:0]  OFF_MAX  = {OFF_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LOOP     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REV_LOOP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ONCE     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REV_ONCE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PINGPONG = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FROZEN   = 3'd5;

  localparam logic [CFG_IW-1:0] REG_RANGE_FIRST = 3'd0;
  localparam logic [CFG_IW-1:0] REG_RANGE_LAST  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MODE        = 3'd2;
  localparam logic [CFG_IW-1:0] REG_INTERVAL    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_COLUMNS     = 3'd4;
  localparam logic [CFG_IW-1:0] REG_TILE_WIDTH  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_TILE_HEIGHT = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [PAT_W-1:0] pattern_value;
  } cmd_t;

  typedef struct packed {
    logic [PAT_W-1:0] pattern_now;
    logic [OFF_W-1:0] offset_u;
    logic [OFF_W-1:0] offset_v;
    logic             finished;
  } res_t;

  typedef struct packed {
    logic [PAT_W-1:0]  range_first;
    logic [PAT_W-1:0]  range_last;
    logic [MODE_W-1:0] mode;
    logic [IVL_W-1:0]  interval;
    logic [COL_W-1:0]  columns;
    logic [TILE_W-1:0] tile_width;
    logic [TILE_W-1:0] tile_height;
  } cfg_t;

  // Work handed from the command front to the offset back end.
  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic             finished;
  } job_t;

endpackage
`default_nettype wire

### hw/rtl/sfs_front.sv
// Command front end: tick counting, pattern stepping per animation mode, set and reset.
`default_nettype none
module sfs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sfs_pkg::cfg_t cfg,
  input  wire logic          push,
  input  wire sfs_pkg::cmd_t cmd,
  input  wire logic          q_full,
  output      logic          q_push,
  output      sfs_pkg::job_t q_job
);
  import sfs_pkg::*;

  logic [PAT_W-1:0]  pattern, pattern_next;
  logic [TICK_W-1:0] tick, tick_next, tick_inc;
  logic              backward, backward_next;
  logic              fin;
  logic [PAT_W-1:0]  step_pat;
  logic              step_back;
  logic              step_fin;

  assign q_push = push && !q_full;
  assign tick_inc = (tick == TICK_MAX) ? tick : tick + 1'b1;

  always_comb begin
    step_pat  = pattern;
    step_back = backward;
    step_fin  = 1'b0;
    unique case (cfg.mode)
      MODE_LOOP: begin
        step_pat = (cfg.range_last > pattern) ? pattern + 1'b1 : cfg.range_first;
      end
      MODE_REV_LOOP: begin
        step_pat = (cfg.range_first < pattern) ? pattern - 1'b1 : cfg.range_last;
      end
      MODE_ONCE: begin
        if (cfg.range_last > pattern) begin
          step_pat = pattern + 1'b1;
        end else begin
          step_pat = cfg.range_last;
          step_fin = 1'b1;
        end
      end
      MODE_REV_ONCE: begin
        if (cfg.range_first < pattern) begin
          step_pat = pattern - 1'b1;
        end else begin
          step_pat = cfg.range_first;
          step_fin = 1'b1;
        end
      end
      MODE_PINGPONG: begin
        // at a bound: flip direction and step one away from it, back into the range
        if (backward) begin
          if (cfg.range_first < pattern) begin
            step_pat = pattern - 1'b1;
          end else begin
            step_pat  = pattern + 1'b1;
            step_back = 1'b0;
          end
        end else begin
          if (cfg.range_last > pattern) begin
            step_pat = pattern + 1'b1;
          end else begin
            step_pat  = pattern - 1'b1;
            step_back = 1'b1;
          end
        end
      end
      default: begin
        // frozen, and the unused codes
      end
    endcase
  end

  always_comb begin
    pattern_next  = pattern;
    tick_next     = tick;
    backward_next = backward;
    fin           = 1'b0;
    if (q_push) begin
      unique case (cmd.command)
        CMD_TICK: begin
          tick_next = tick_inc;
          if (TICK_W'(cfg.interval) < tick_inc) begin
            pattern_next  = step_pat;
            backward_next = step_back;
            fin           = step_fin;
            tick_next     = '0;
          end
        end
        CMD_SET:   pattern_next = cmd.pattern_value;
        CMD_RESET: pattern_next = cfg.range_first;
        default: begin
        end
      endcase
    end
  end

  assign q_job.pattern  = pattern_next;
  assign q_job.finished = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern  <= '0;
      tick     <= '0;
      backward <= 1'b0;
    end else begin
      pattern  <= pattern_next;
      tick     <= tick_next;
      backward <= backward_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sfs_queue.sv
// Short queue of jobs between the front end and the back end.
`default_nettype none
module sfs_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire sfs_pkg::job_t wr_job,
  output      logic          full,
  input  wire logic          rd,
  output      logic          valid,
  output      sfs_pkg::job_t rd_job
);
  import sfs_pkg::*;

  job_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_CW-1:0] count;

  assign full   = (count == Q_CW'(Q_DEPTH));
  assign valid  = (count != '0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        slots[wr_ptr] <= wr_job;
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sfs_back.sv
// Back end: serial column/row divide, offset multiply, saturate, result register.
`default_nettype none
module sfs_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sfs_pkg::cfg_t cfg,
  input  wire logic          q_valid,
  input  wire sfs_pkg::job_t q_job,
  output      logic          q_pop,
  input  wire logic          pop,
  output      logic          res_valid,
  output      sfs_pkg::res_t res
);
  import sfs_pkg::*;

  localparam int CNT_W = $clog2(PAT_W);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [PAT_W-1:0]  pat, quo;
  logic [COL_W-1:0]  rem, divisor;
  logic              fin;
  logic [COL_W:0]    rem_sh;
  logic              ge;
  logic [PROD_W-1:0] prod_u, prod_v;
  logic              out_free;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign rem_sh   = {rem, quo[PAT_W-1]};
  assign ge       = (rem_sh >= {1'b0, divisor});
  assign out_free = !res_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            pat     <= q_job.pattern;
            quo     <= q_job.pattern;
            fin     <= q_job.finished;
            rem     <= '0;
            divisor <= (cfg.columns == '0) ? COL_W'(1) : cfg.columns;
            cnt     <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          rem   <= ge ? COL_W'(rem_sh - {1'b0, divisor}) : rem_sh[COL_W-1:0];
          quo   <= {quo[PAT_W-2:0], ge};
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_W'(PAT_W - 1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          // rem is the column, quo the row
          prod_u <= PROD_W'(rem) * PROD_W'(cfg.tile_width);
          prod_v <= PROD_W'(quo) * PROD_W'(cfg.tile_height);
          state  <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            res.pattern_now <= pat;
            res.offset_u    <= (prod_u > PROD_W'(OFF_MAX)) ? OFF_MAX : prod_u[OFF_W-1:0];
            res.offset_v    <= (prod_v > PROD_W'(OFF_MAX)) ? OFF_MAX : prod_v[OFF_W-1:0];
            res.finished    <= fin;
            res_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sprite_frame_sequencer.sv
// Sprite frame sequencer top level: config registers, front end, queue, back end.
//
// Commands enter on cmd with push/full (accepted when push && !full): frame
// tick, set pattern, or reset pattern to range_first. Every command yields
// one result: the pattern after it, its texture offsets (column and row of
// the pattern times tile width and height, saturated to 24 bits) and the
// finished flag of the once modes. Results leave on res with empty/pop, the
// oldest first; the result stays on res until popped.
// The front end applies each command in the cycle it is accepted and queues
// the pattern in a two-entry queue, so a few commands are taken back to back.
// The back end works on one item at a time: one load, 8 restoring-divide steps
// for column and row, one multiply, one saturate and write. That serial
// divider limits the sustained result rate; the back end takes no new item
// from the queue until it has written the result of the last one.
// If res is not popped, the back end holds its finished item, the queue
// fills and full rises. Config writes (cfg_valid/cfg_ready, cfg_ready always
// high) are taken any cycle and are meant only while no command is pending.
// Reset (rst, synchronous) clears the pattern, tick count and ping-pong
// direction and loads the register defaults; the block is ready at once.
`default_nettype none
module sprite_frame_sequencer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sfs_pkg::cmd_t                cmd,
  input  wire logic                         push,
  output      logic                         full,
  output      sfs_pkg::res_t                res,
  output      logic                         empty,
  input  wire logic                         pop,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [sfs_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [sfs_pkg::CFG_DW-1:0]   cfg_data
);
  import sfs_pkg::*;

  cfg_t cfg;
  logic q_push, q_full, q_pop, q_valid, res_valid;
  job_t q_in, q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_first <= '0;
      cfg.range_last  <= '0;
      cfg.mode        <= MODE_LOOP;
      cfg.interval    <= IVL_W'(1);
      cfg.columns     <= COL_W'(1);
      cfg.tile_width  <= TILE_W'(65536);
      cfg.tile_height <= TILE_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RANGE_FIRST: cfg.range_first <= cfg_data[PAT_W-1:0];
        REG_RANGE_LAST:  cfg.range_last  <= cfg_data[PAT_W-1:0];
        REG_MODE:        cfg.mode        <= cfg_data[MODE_W-1:0];
        REG_INTERVAL:    cfg.interval    <= cfg_data[IVL_W-1:0];
        REG_COLUMNS:     cfg.columns     <= cfg_data[COL_W-1:0];
        REG_TILE_WIDTH:  cfg.tile_width  <= cfg_data[TILE_W-1:0];
        REG_TILE_HEIGHT: cfg.tile_height <= cfg_data[TILE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign full = q_full;

  sfs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .cmd    (cmd),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_in)
  );

  sfs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_job (q_in),
    .full   (q_full),
    .rd     (q_pop),
    .valid  (q_valid),
    .rd_job (q_out)
  );

  sfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_job     (q_out),
    .q_pop     (q_pop),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign empty = !res_valid;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_fin_once_only: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.finished) |->
      (cfg.mode == MODE_ONCE || cfg.mode == MODE_REV_ONCE))
    else $error("finished flagged outside a once mode");

  a_u_zero_width: assert property (@(posedge clk) disable iff (rst)
    (!empty && cfg.tile_width == '0) |-> (res.offset_u == '0))
    else $error("nonzero u offset with zero tile width");

endmodule
`default_nettype wire
